@@ hw/rtl/voxel_face_cull_mesher_macros.svh @@
// Assertion macros for the port-level checker file
`ifndef VOXEL_FACE_CULL_MESHER_MACROS_SVH
`define VOXEL_FACE_CULL_MESHER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define VFC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vfc check failed");

// Next-cycle implication, sampled on clk, off during reset
`define VFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vfc check failed");

`endif

@@ hw/rtl/vfc_pkg.sv @@
// Package: shared types, constants and microcode for the voxel face mesher
package vfc_pkg;

  localparam int CHUNK_EDGE  = 32;
  localparam int BLOCK_TYPES = 256;
  localparam int FACES       = 6;
  localparam int CORNERS     = 6;
  localparam int TEX_DEPTH   = BLOCK_TYPES * FACES;
  localparam int TEX_AW      = $clog2(TEX_DEPTH);
  localparam int FACE_W      = $clog2(FACES);
  localparam int CORNER_W    = $clog2(CORNERS);
  localparam int CFG_IW      = 1;

  localparam logic [2:0] OP_MESH      = 3'd0;
  localparam logic [2:0] OP_WR_FIRST  = 3'd1;
  localparam logic [2:0] OP_WR_LAST   = 3'd6;

  localparam logic [CFG_IW-1:0] REG_AIR_ID   = 1'd0;
  localparam logic [CFG_IW-1:0] REG_GLASS_ID = 1'd1;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] voxel_x;
    logic [4:0] voxel_y;
    logic [4:0] voxel_z;
    logic [7:0] block_id;
    logic [7:0] neighbor_neg_x;
    logic [7:0] neighbor_pos_x;
    logic [7:0] neighbor_neg_y;
    logic [7:0] neighbor_pos_y;
    logic [7:0] neighbor_neg_z;
    logic [7:0] neighbor_pos_z;
    logic [7:0] texture_value;
  } in_item_t;

  typedef struct packed {
    logic [30:0] vertex_word;
    logic        last_vertex;
  } out_item_t;

  // Corner entry: {dx, dy, dz, u, v}; faces in scan order -x, +x, -z, +z, -y, +y
  localparam logic [4:0] CORNER_TAB [FACES][CORNERS] = '{
    '{5'b00000, 5'b01111, 5'b01001, 5'b00000, 5'b00110, 5'b01111},
    '{5'b10010, 5'b11101, 5'b10100, 5'b10010, 5'b11011, 5'b11101},
    '{5'b00000, 5'b11011, 5'b10010, 5'b00000, 5'b01001, 5'b11011},
    '{5'b00100, 5'b10110, 5'b11111, 5'b00100, 5'b11111, 5'b01101},
    '{5'b00000, 5'b10010, 5'b10111, 5'b00000, 5'b10111, 5'b00101},
    '{5'b01001, 5'b01100, 5'b11110, 5'b01001, 5'b11110, 5'b11011}
  };
  localparam logic [2:0] NORMAL_TAB [FACES] = '{3'd3, 3'd2, 3'd5, 3'd4, 3'd1, 3'd0};
  localparam logic [2:0] COLUMN_TAB [FACES] = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd3, 3'd2};

  // Sequencer steps
  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_EMIT
  } step_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_START,
    C_FACE_DONE,
    C_LAST_DONE
  } cond_t;

  typedef struct packed {
    logic acc_en;
    logic find_en;
    logic emit_en;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic face_done;
    logic last_done;
  } flags_t;

  // One control word: datapath enables and two prioritized jumps
  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond_a;
    step_t jump_a;
    cond_t cond_b;
    step_t jump_b;
  } cw_t;

  function automatic cw_t ucode(input step_t step);
    cw_t cw;
    unique case (step)
      S_IDLE:  cw = '{ctrl: '{1'b1, 1'b0, 1'b0}, cond_a: C_START, jump_a: S_FIND,
                      cond_b: C_NEVER, jump_b: S_IDLE};
      S_FIND:  cw = '{ctrl: '{1'b0, 1'b1, 1'b0}, cond_a: C_ALWAYS, jump_a: S_EMIT,
                      cond_b: C_NEVER, jump_b: S_IDLE};
      S_EMIT:  cw = '{ctrl: '{1'b0, 1'b0, 1'b1}, cond_a: C_LAST_DONE, jump_a: S_IDLE,
                      cond_b: C_FACE_DONE, jump_b: S_FIND};
      default: cw = '{ctrl: '{1'b1, 1'b0, 1'b0}, cond_a: C_ALWAYS, jump_a: S_IDLE,
                      cond_b: C_NEVER, jump_b: S_IDLE};
    endcase
    return cw;
  endfunction

  function automatic logic cond_true(input cond_t c, input flags_t f);
    logic r;
    unique case (c)
      C_NEVER:     r = 1'b0;
      C_ALWAYS:    r = 1'b1;
      C_START:     r = f.start;
      C_FACE_DONE: r = f.face_done;
      C_LAST_DONE: r = f.last_done;
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/vfc_seq.sv @@
// Microcoded sequencer: step register, control store and jump logic
module vfc_seq
  import vfc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  step_t step_r, step_nxt;
  cw_t   cw;

  assign cw = ucode(step_r);

  always_comb begin
    priority if (cond_true(cw.cond_a, flags)) begin
      step_nxt = cw.jump_a;
    end else if (cond_true(cw.cond_b, flags)) begin
      step_nxt = cw.jump_b;
    end else begin
      step_nxt = step_r;
    end
  end

  always_comb begin
    ctrl = cw.ctrl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ hw/rtl/voxel_face_cull_mesher.sv @@
// Top level: voxel face-culling mesher with face texture table and output register
// First vertex word path: table lookup step, first word step, then the output register drives out_valid.
// Per request: the idle step takes it, then per exposed face one table lookup step
//   and six word steps; no new request is taken until the run returns to idle,
//   and a stalled output holds the word steps.
// Table writes, air voxels and hidden voxels are taken in the idle step and start no run.
// Reset (rst_n low, synchronous): sequencer idle, output empty, air_id and glass_id
//   zero; the texture table is not cleared and holds garbage until written.
module voxel_face_cull_mesher
  import vfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [7:0]        cfg_wdata
);

  // Configuration registers
  logic [7:0] air_id_r, glass_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      air_id_r   <= '0;
      glass_id_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AIR_ID:   air_id_r   <= cfg_wdata;
        REG_GLASS_ID: glass_id_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer
  ctrl_t  ctrl;
  flags_t flags;

  vfc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Request decode: accept only while the sequencer sits in its idle step
  logic             in_fire;
  logic             is_mesh, is_write, row_ok, pos_ok;
  logic [FACES-1:0] see_mask;

  assign in_stall = !ctrl.acc_en;
  assign in_fire  = in_valid && ctrl.acc_en;
  assign is_mesh  = (in_data.op == OP_MESH);
  assign is_write = (in_data.op >= OP_WR_FIRST) && (in_data.op <= OP_WR_LAST);
  assign row_ok   = (int'(in_data.block_id) < BLOCK_TYPES);
  assign pos_ok   = (int'(in_data.voxel_x) < CHUNK_EDGE) &&
                    (int'(in_data.voxel_y) < CHUNK_EDGE) &&
                    (int'(in_data.voxel_z) < CHUNK_EDGE);

  function automatic logic see_through(input logic [7:0] t, input logic [7:0] air,
                                       input logic [7:0] glass);
    return (t == air) || (t == glass);
  endfunction

  // Mask bits in scan order -x, +x, -z, +z, -y, +y
  always_comb begin
    see_mask[0] = see_through(in_data.neighbor_neg_x, air_id_r, glass_id_r);
    see_mask[1] = see_through(in_data.neighbor_pos_x, air_id_r, glass_id_r);
    see_mask[2] = see_through(in_data.neighbor_neg_z, air_id_r, glass_id_r);
    see_mask[3] = see_through(in_data.neighbor_pos_z, air_id_r, glass_id_r);
    see_mask[4] = see_through(in_data.neighbor_neg_y, air_id_r, glass_id_r);
    see_mask[5] = see_through(in_data.neighbor_pos_y, air_id_r, glass_id_r);
  end

  assign flags.start = in_fire && is_mesh && pos_ok &&
                       (in_data.block_id != air_id_r) && (see_mask != '0);

  // Item registers: hold the voxel for the whole run
  logic [4:0]          x_r, y_r, z_r;
  logic [7:0]          blk_r;
  logic                row_ok_r;
  logic [FACES-1:0]    mask_r;
  logic [FACE_W-1:0]   face_r;
  logic [CORNER_W-1:0] corner_r;

  // Lowest pending face
  logic [FACE_W-1:0] face_pick;
  always_comb begin
    face_pick = '0;
    for (int i = FACES - 1; i >= 0; i--) begin
      if (mask_r[i]) face_pick = FACE_W'(i);
    end
  end

  logic             emit_fire, corner_end;
  logic [FACES-1:0] mask_left;

  assign emit_fire  = ctrl.emit_en && (!out_valid || !out_stall);
  assign corner_end = (int'(corner_r) == CORNERS - 1);

  always_comb begin
    mask_left         = mask_r;
    mask_left[face_r] = 1'b0;
  end

  assign flags.face_done = emit_fire && corner_end;
  assign flags.last_done = emit_fire && corner_end && (mask_left == '0);

  always_ff @(posedge clk) begin
    if (flags.start) begin
      x_r      <= in_data.voxel_x;
      y_r      <= in_data.voxel_y;
      z_r      <= in_data.voxel_z;
      blk_r    <= in_data.block_id;
      row_ok_r <= row_ok;
      mask_r   <= see_mask;
    end else if (flags.face_done) begin
      // drop the finished face from the pending set
      mask_r <= mask_left;
    end
    if (ctrl.find_en) begin
      face_r   <= face_pick;
      corner_r <= '0;
    end else if (emit_fire) begin
      corner_r <= corner_r + CORNER_W'(1);
    end
  end

  // Face texture table: written by write requests, read once per face
  logic [7:0]        tex_mem [TEX_DEPTH];
  logic [7:0]        tex_rd_r;
  logic              tex_we;
  logic [TEX_AW-1:0] tex_waddr, tex_raddr;

  assign tex_we    = in_fire && is_write && row_ok;
  assign tex_waddr = TEX_AW'(in_data.block_id) * TEX_AW'(FACES) +
                     TEX_AW'(in_data.op - OP_WR_FIRST);
  assign tex_raddr = TEX_AW'(blk_r) * TEX_AW'(FACES) + TEX_AW'(COLUMN_TAB[face_pick]);

  always_ff @(posedge clk) begin
    if (tex_we) begin
      tex_mem[tex_waddr] <= in_data.texture_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.find_en) begin
      tex_rd_r <= tex_mem[tex_raddr];
    end
  end

  // Vertex word assembly
  logic [4:0]  corner;
  logic [5:0]  vx, vy, vz;
  logic [7:0]  tex;
  logic [30:0] word;

  assign corner = CORNER_TAB[face_r][corner_r];
  assign vx     = {1'b0, x_r} + 6'(corner[4]);
  assign vy     = {1'b0, y_r} + 6'(corner[3]);
  assign vz     = {1'b0, z_r} + 6'(corner[2]);
  assign tex    = row_ok_r ? tex_rd_r : 8'd0;
  assign word   = {corner[0], corner[1], tex, NORMAL_TAB[face_r], vz, vy, vx};

  // Output register: advance when empty or when the held word is taken
  logic      out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data_r.vertex_word <= word;
      out_data_r.last_vertex <= flags.last_done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/vfc_checker.sv @@
// Port-level checker for the voxel face mesher, bound to the top level
`include "voxel_face_cull_mesher_macros.svh"

module vfc_checker
  import vfc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A held word that is not the last means the voxel run is still going
  `VFC_ASSERT_SAME(a_busy_mid_run, out_valid && !out_data.last_vertex, in_stall)

  // Normal code is always one of the six face codes
  `VFC_ASSERT_SAME(a_normal_range, out_valid,
    (out_data.vertex_word[20:18] != 3'd6) && (out_data.vertex_word[20:18] != 3'd7))

  // A table write or an unknown code leaves the block ready for the next request
  `VFC_ASSERT_NEXT(a_write_no_run, in_valid && !in_stall && (in_data.op != OP_MESH),
    !in_stall)

  // A stalled result holds
  `VFC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind voxel_face_cull_mesher vfc_checker u_vfc_checker (.*);
